[rtl/core/direct_mapped_block_cache_tags_defines.svh]
// Assertion macros for the cache tag directory checker.
`ifndef DIRECT_MAPPED_BLOCK_CACHE_TAGS_DEFINES_SVH
`define DIRECT_MAPPED_BLOCK_CACHE_TAGS_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define DMBC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dmbc assertion failed");

// Next-cycle implication, off while reset is high.
`define DMBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dmbc assertion failed");

// Next-cycle implication that also holds across reset.
`define DMBC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("dmbc assertion failed");

`endif

[rtl/core/dmbc_pkg.sv]
// Types and constants shared by the cache tag directory modules.
package dmbc_pkg;

   localparam int LINE_INDEX_W = 4;
   localparam int WORD_W       = 32;

   typedef enum logic [1:0] {
      CMD_LOOKUP     = 2'd0,
      CMD_INSTALL    = 2'd1,
      CMD_INVALIDATE = 2'd2,
      CMD_SET_BASE   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             command;
      logic [WORD_W-1:0]   block_number;
      logic [WORD_W-1:0]   block_count;
      logic [WORD_W-1:0]   new_base_sector;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic [LINE_INDEX_W-1:0] line_index;
      logic [WORD_W-1:0]       sector_address;
      logic [WORD_W-1:0]       sector_count;
   } rsp_type;

endpackage

[rtl/core/dmbc_line_map.sv]
// Block number to line index: residue modulo LINES via byte residue tables.
module dmbc_line_map #(
   parameter int LINES = 16
) (
   input  logic [dmbc_pkg::WORD_W-1:0] block_number,
   output logic [$clog2(LINES)-1:0]    line_idx
);

   localparam int IDX_W = $clog2(LINES);
   localparam int SUM_W = $clog2(4 * LINES);
   localparam int WEIGHT [4] = '{1 % LINES, 256 % LINES, 65536 % LINES, 16777216 % LINES};

   logic [IDX_W-1:0] res_tab [4][256];
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] red;

   for (genvar k = 0; k < 4; k++) begin : g_byte
      for (genvar b = 0; b < 256; b++) begin : g_entry
         assign res_tab[k][b] = IDX_W'((b * WEIGHT[k]) % LINES);
      end
   end

   always_comb begin
      sum = SUM_W'(res_tab[0][block_number[7:0]])
          + SUM_W'(res_tab[1][block_number[15:8]])
          + SUM_W'(res_tab[2][block_number[23:16]])
          + SUM_W'(res_tab[3][block_number[31:24]]);
      red = (sum >= SUM_W'(2 * LINES)) ? sum - SUM_W'(2 * LINES) : sum;
      line_idx = (red >= SUM_W'(LINES)) ? IDX_W'(red - SUM_W'(LINES)) : IDX_W'(red);
   end

endmodule

[rtl/core/dmbc_directory.sv]
// Tag, valid and base state with the per-command result and update logic.
module dmbc_directory #(
   parameter int LINES                   = 16,
   parameter int SECTORS_PER_BLOCK_COUNT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  dmbc_pkg::req_type        req,
   input  logic [$clog2(LINES)-1:0] line_idx,
   output dmbc_pkg::rsp_type        rsp
);

   localparam logic [dmbc_pkg::WORD_W-1:0] SPB = dmbc_pkg::WORD_W'(SECTORS_PER_BLOCK_COUNT);

   logic [dmbc_pkg::WORD_W-1:0] tag_ff [LINES];
   logic [LINES-1:0]            valid_ff;
   logic [LINES-1:0]            valid_in;
   logic [dmbc_pkg::WORD_W-1:0] base_ff;
   logic [dmbc_pkg::WORD_W-1:0] base_in;
   logic                        tag_we;
   logic                        match;
   logic [dmbc_pkg::WORD_W-1:0] blk_addr;

   assign match    = valid_ff[line_idx] && (tag_ff[line_idx] == req.block_number);
   assign blk_addr = base_ff + req.block_number * SPB;

   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      tag_we   = 1'b0;
      rsp.hit            = 1'b0;
      rsp.line_index     = dmbc_pkg::LINE_INDEX_W'(line_idx);
      rsp.sector_address = blk_addr;
      rsp.sector_count   = SPB;
      case (req.command)
         dmbc_pkg::CMD_LOOKUP: begin
            rsp.hit = match;
         end
         dmbc_pkg::CMD_INSTALL: begin
            rsp.hit = match;
            if (!match) begin
               tag_we             = 1'b1;
               valid_in[line_idx] = 1'b1;
            end
         end
         dmbc_pkg::CMD_INVALIDATE: begin
            for (int i = 0; i < LINES; i++) begin
               if (valid_ff[i] && ((tag_ff[i] - req.block_number) < req.block_count)) begin
                  valid_in[i] = 1'b0;
               end
            end
            rsp.sector_count = req.block_count * SPB;
         end
         dmbc_pkg::CMD_SET_BASE: begin
            if (req.new_base_sector != base_ff) begin
               valid_in = '0;
               base_in  = req.new_base_sector;
            end
            rsp.line_index     = '0;
            rsp.sector_address = req.new_base_sector;
            rsp.sector_count   = '0;
         end
         default: begin
            rsp.hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         base_ff  <= '0;
      end else if (fire) begin
         valid_ff <= valid_in;
         base_ff  <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && tag_we) begin
         tag_ff[line_idx] <= req.block_number;
      end
   end

endmodule

[rtl/core/direct_mapped_block_cache_tags.sv]
// Top level of the direct-mapped block cache tag directory.
//
//   channel | direction | payload            | transfer
//   req     | in        | dmbc_pkg::req_type | req_valid & req_ready
//   rsp     | out       | dmbc_pkg::rsp_type | rsp_valid & rsp_ready
//
// One command per cycle while results are taken; a request passes through the input register,
// the directory logic and the result register before its result shows.
// Directory state updates as a command moves from the input register to the result.
// Reset clears all valid bits and the sector base.
// A stalled result holds; the input register takes one more command meanwhile if it is empty.
module direct_mapped_block_cache_tags #(
   parameter int LINES                   = 16,
   parameter int SECTORS_PER_BLOCK_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dmbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmbc_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(LINES);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   dmbc_pkg::req_type s1_ff;
   dmbc_pkg::req_type s1_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   dmbc_pkg::rsp_type rsp_ff;
   dmbc_pkg::rsp_type rsp_in;
   logic              s1_move;
   logic [IDX_W-1:0]  line_idx;
   dmbc_pkg::rsp_type dir_rsp;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dmbc_line_map #(
      .LINES(LINES)
   ) u_line_map (
      .block_number(s1_ff.block_number),
      .line_idx    (line_idx)
   );

   dmbc_directory #(
      .LINES                  (LINES),
      .SECTORS_PER_BLOCK_COUNT(SECTORS_PER_BLOCK_COUNT)
   ) u_directory (
      .clock   (clock),
      .reset   (reset),
      .fire    (s1_move),
      .req     (s1_ff),
      .line_idx(line_idx),
      .rsp     (dir_rsp)
   );

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_move);
      s1_in        = (req_valid && req_ready) ? req_data : s1_ff;
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
      rsp_in       = s1_move ? dir_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/core/dmbc_checker.sv]
// Port-level assertions for the cache tag directory, bound to the top level.
`include "direct_mapped_block_cache_tags_defines.svh"

module dmbc_checker #(
   parameter int SECTORS_PER_BLOCK_COUNT = 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dmbc_pkg::rsp_type rsp_data
);

   `DMBC_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, reset, !rsp_valid)
   `DMBC_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `DMBC_ASSERT_NEXT(a_req_reaches_rsp, req_valid && req_ready, ##1 rsp_valid)
   `DMBC_ASSERT_SAME(a_stall_only_on_rsp, !req_ready, rsp_valid && !rsp_ready)
   `DMBC_ASSERT_SAME(a_hit_block_count, rsp_valid && rsp_data.hit,
      rsp_data.sector_count == dmbc_pkg::WORD_W'(SECTORS_PER_BLOCK_COUNT))

endmodule

bind direct_mapped_block_cache_tags dmbc_checker #(
   .SECTORS_PER_BLOCK_COUNT(SECTORS_PER_BLOCK_COUNT)
) u_dmbc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

[sim/tb_direct_mapped_block_cache_tags.sv]
// Self-checking testbench for the direct-mapped block cache tag directory.
`timescale 1ns / 1ps

module tb_direct_mapped_block_cache_tags;

   localparam int          LINES       = 16;
   localparam logic [31:0] SECTORS     = 32'd8;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_WAIT  = 10;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dmbc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   dmbc_pkg::rsp_type rsp_data;

   logic [31:0] tag_q [LINES];
   logic        valid_q [LINES];
   logic [31:0] base_q;

   dmbc_pkg::rsp_type expected_q [$];
   dmbc_pkg::rsp_type want;
   int                error_count;
   int                cycle_count;
   bit                burst_mode;
   logic [31:0]       anchors [3];

   direct_mapped_block_cache_tags #(
      .LINES                  (LINES),
      .SECTORS_PER_BLOCK_COUNT(8)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function dmbc_pkg::rsp_type predict_directory(input dmbc_pkg::req_type r);
      dmbc_pkg::rsp_type res;
      logic [3:0]        idx;
      logic [31:0]       offset;
      idx                = r.block_number[3:0];
      res.hit            = 1'b0;
      res.line_index     = idx;
      res.sector_address = base_q + r.block_number * SECTORS;
      res.sector_count   = SECTORS;
      case (r.command)
         dmbc_pkg::CMD_LOOKUP: begin
            res.hit = valid_q[idx] && (tag_q[idx] == r.block_number);
         end
         dmbc_pkg::CMD_INSTALL: begin
            if (valid_q[idx] && (tag_q[idx] == r.block_number)) begin
               res.hit = 1'b1;
            end else begin
               tag_q[idx]   = r.block_number;
               valid_q[idx] = 1'b1;
            end
         end
         dmbc_pkg::CMD_INVALIDATE: begin
            for (int i = 0; i < LINES; i++) begin
               offset = tag_q[i] - r.block_number;
               if (valid_q[i] && (offset < r.block_count)) valid_q[i] = 1'b0;
            end
            res.sector_count = r.block_count * SECTORS;
         end
         default: begin
            if (r.new_base_sector != base_q) begin
               for (int i = 0; i < LINES; i++) valid_q[i] = 1'b0;
               base_q = r.new_base_sector;
            end
            res.line_index     = '0;
            res.sector_address = base_q;
            res.sector_count   = '0;
         end
      endcase
      return res;
   endfunction

   task automatic send_cmd(input dmbc_pkg::cmd_type c, input logic [31:0] blk,
                           input logic [31:0] cnt, input logic [31:0] nbase);
      dmbc_pkg::req_type r;
      int                gap;
      r.command         = c;
      r.block_number    = blk;
      r.block_count     = cnt;
      r.new_base_sector = nbase;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_directory(r));
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // result side back-pressure
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         n = pick_gap();
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: hit=%b line=%h addr=%h count=%h",
                        rsp_data.hit, rsp_data.line_index,
                        rsp_data.sector_address, rsp_data.sector_count);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.line_index !== want.line_index ||
                rsp_data.sector_address !== want.sector_address ||
                rsp_data.sector_count !== want.sector_count) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: exp hit=%b line=%h addr=%h count=%h, ",
                            "got hit=%b line=%h addr=%h count=%h"},
                           want.hit, want.line_index, want.sector_address, want.sector_count,
                           rsp_data.hit, rsp_data.line_index,
                           rsp_data.sector_address, rsp_data.sector_count);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** direct_mapped_block_cache_tags: FAILED **");
      $finish;
   end

   task automatic test_cold_lookup();
      send_cmd(dmbc_pkg::CMD_LOOKUP, 32'h0000_0000, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
   endtask

   task automatic test_install_hit();
      send_cmd(dmbc_pkg::CMD_INSTALL, 32'h0000_0025, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INSTALL, 32'h0000_0025, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP,  32'h0000_0025, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INSTALL, 32'h0000_0035, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP,  32'h0000_0025, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INSTALL, 32'hFFFF_FFFF, $urandom, $urandom);
   endtask

   task automatic test_range_invalidate();
      send_cmd(dmbc_pkg::CMD_INSTALL,    32'h0000_0010, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INSTALL,    32'h0000_0011, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INVALIDATE, 32'h0000_0010, 32'd0, $urandom);
      send_cmd(dmbc_pkg::CMD_INVALIDATE, 32'h0000_0011, 32'd1, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP,     32'h0000_0011, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INSTALL,    32'hFFFF_FFFE, $urandom, $urandom);
      // wraps past the top; stops just short of block 0x10
      send_cmd(dmbc_pkg::CMD_INVALIDATE, 32'hFFFF_FFF0, 32'h0000_0020, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP,     32'h0000_0010, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_LOOKUP,     32'hFFFF_FFFE, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_INVALIDATE, 32'h0000_0000, 32'hFFFF_FFFF, $urandom);
   endtask

   task automatic test_set_base();
      send_cmd(dmbc_pkg::CMD_INSTALL,  32'h0000_0007, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_SET_BASE, $urandom, $urandom, base_q);
      send_cmd(dmbc_pkg::CMD_LOOKUP,   32'h0000_0007, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_SET_BASE, $urandom, $urandom, 32'hFFFF_FFFF);
      send_cmd(dmbc_pkg::CMD_LOOKUP,   32'h0000_0007, $urandom, $urandom);
      send_cmd(dmbc_pkg::CMD_SET_BASE, $urandom, $urandom, 32'hFFFF_FFFF);
   endtask

   function automatic logic [31:0] pick_block();
      if ($urandom_range(0, 9) < 7)
         return anchors[$urandom_range(0, 2)] + $urandom_range(0, 47);
      return $urandom;
   endfunction

   task automatic test_random_traffic(input int n_items);
      int          r;
      logic [31:0] cnt;
      logic [31:0] nbase;
      anchors[0] = 32'h0000_0000;
      anchors[1] = 32'hFFFF_FFE0;
      anchors[2] = $urandom;
      for (int k = 0; k < n_items; k++) begin
         if (k % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_cmd(dmbc_pkg::CMD_LOOKUP, pick_block(), $urandom, $urandom);
         end else if (r < 72) begin
            send_cmd(dmbc_pkg::CMD_INSTALL, pick_block(), $urandom, $urandom);
         end else if (r < 92) begin
            r = $urandom_range(0, 9);
            if (r < 6)      cnt = $urandom_range(0, 40);
            else if (r < 8) cnt = $urandom_range(0, 3);
            else            cnt = $urandom;
            send_cmd(dmbc_pkg::CMD_INVALIDATE, pick_block(), cnt, $urandom);
         end else begin
            r = $urandom_range(0, 3);
            if (r < 2)       nbase = base_q;
            else if (r == 2) nbase = base_q + $urandom_range(1, 16);
            else             nbase = $urandom;
            send_cmd(dmbc_pkg::CMD_SET_BASE, $urandom, $urandom, nbase);
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      error_count = 0;
      burst_mode  = 1'b0;
      base_q      = '0;
      for (int i = 0; i < LINES; i++) begin
         tag_q[i]   = '0;
         valid_q[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cold_lookup();
      test_install_hit();
      test_range_invalidate();
      test_set_base();
      test_random_traffic(450);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("** direct_mapped_block_cache_tags: PASSED **");
      else
         $display("** direct_mapped_block_cache_tags: FAILED **");
      $finish;
   end

endmodule
